// ----- hw/rtl/epd_pkg.sv -----
// Shared types, constants and the word decode function for the encoder packet decoder.
// No dependencies; imported by every module of the block.
package epd_pkg;

  localparam int unsigned ANGLE_W     = 13;
  localparam int unsigned NUM_WORDS   = 3;
  localparam int unsigned NUM_PAYLOAD = 6;

  localparam logic [7:0] HDR_BYTE = 8'hAA;
  localparam int unsigned BAD_BIT = 13;

  // Byte position codes: hunting for the header, expecting the first payload byte, or expecting the checksum.
  localparam logic [2:0] POS_HUNT  = 3'd0;
  localparam logic [2:0] POS_FIRST = 3'd1;
  localparam logic [2:0] POS_CHECK = 3'd7;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OFFSET_ONE   = 2'd0;
  localparam logic [1:0] CFG_OFFSET_TWO   = 2'd1;
  localparam logic [1:0] CFG_OFFSET_THREE = 2'd2;

  typedef logic [ANGLE_W-1:0] angle_t;

  // Completed packet waiting for decode.
  typedef struct packed {
    logic                       valid;
    logic [NUM_WORDS-1:0][15:0] word;
    logic                       checksum_ok;
  } pkt_t;

  typedef struct packed {
    angle_t angle;
    logic   ok;
  } decoded_t;

  // Bit 13 set marks a bad reading; pass its low bits raw, else remove the offset mod 8192.
  function automatic decoded_t decode_word(input logic [15:0] word, input angle_t offset);
    decoded_t res;
    angle_t   raw;
    raw = word[ANGLE_W-1:0];
    if (word[BAD_BIT]) begin
      res.ok    = 1'b0;
      res.angle = raw;
    end else begin
      res.ok    = 1'b1;
      res.angle = raw - offset;
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/epd_frame.sv -----
// Byte framer: header hunt, payload capture, running checksum, packet register.
// Depends on epd_pkg.
module epd_frame import epd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output pkt_t       pkt,
  output logic [2:0] pos
);

  logic [7:0]                 sum;
  logic [7:0]                 payload [NUM_PAYLOAD];
  logic                       pkt_valid;
  logic [NUM_WORDS-1:0][15:0] pkt_word;
  logic                       pkt_sum_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= POS_HUNT;
      sum       <= 8'd0;
      pkt_valid <= 1'b0;
    end else begin
      // A new packet lands when the register is empty or the previous one moves on in the same cycle.
      if (accept && pos == POS_CHECK) begin
        pkt_valid <= 1'b1;
      end else if (advance) begin
        pkt_valid <= 1'b0;
      end
      if (accept) begin
        case (pos)
          POS_HUNT: begin
            if (rx_byte == HDR_BYTE) begin
              pos <= POS_FIRST;
              sum <= 8'd0;
            end
          end
          POS_CHECK: begin
            pos <= POS_HUNT;
            sum <= 8'd0;
          end
          default: begin
            sum <= sum + rx_byte;
            pos <= pos + 3'd1;
          end
        endcase
      end
    end
  end

  // Payload and packet data carry no reset.
  always_ff @(posedge clk) begin
    if (accept && pos != POS_HUNT && pos != POS_CHECK) begin
      payload[pos - 3'd1] <= rx_byte;
    end
    if (accept && pos == POS_CHECK) begin
      pkt_word[0] <= {payload[1], payload[0]};
      pkt_word[1] <= {payload[3], payload[2]};
      pkt_word[2] <= {payload[5], payload[4]};
      pkt_sum_ok  <= (sum == rx_byte);
    end
  end

  assign pkt = '{valid: pkt_valid, word: pkt_word, checksum_ok: pkt_sum_ok};

endmodule

// ----- hw/rtl/epd_result.sv -----
// Angle decode and result register with valid/stall handshake.
// Depends on epd_pkg.
module epd_result import epd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  pkt_t   pkt,
  input  angle_t offset_one,
  input  angle_t offset_two,
  input  angle_t offset_three,
  input  logic   out_stall,
  output logic   advance,
  output logic   out_valid,
  output angle_t angle_one,
  output angle_t angle_two,
  output angle_t angle_three,
  output logic   valid_one,
  output logic   valid_two,
  output logic   valid_three,
  output logic   checksum_ok
);

  decoded_t dec_one, dec_two, dec_three;

  assign dec_one   = decode_word(pkt.word[0], offset_one);
  assign dec_two   = decode_word(pkt.word[1], offset_two);
  assign dec_three = decode_word(pkt.word[2], offset_three);

  // Load when the result register is empty or its transaction completes this cycle.
  assign advance = pkt.valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      angle_one   <= dec_one.angle;
      angle_two   <= dec_two.angle;
      angle_three <= dec_three.angle;
      valid_one   <= dec_one.ok;
      valid_two   <= dec_two.ok;
      valid_three <= dec_three.ok;
      checksum_ok <= pkt.checksum_ok;
    end
  end

endmodule

// ----- hw/rtl/encoder_packet_decoder.sv -----
// Top level of the encoder packet decoder: offset registers, framer and result stage.
// Depends on epd_pkg, epd_frame and epd_result.
//
// Takes one received byte per cycle while in_stall is low. Bytes are dropped until the
// header 0xAA; the next six bytes are three little-endian encoder words and the eighth is
// the checksum (8-bit sum of the six). On the checksum byte one result is produced: three
// angles in 1/8192 turn with offsets removed (raw for words with bit 13 set), three valid
// flags and checksum_ok. The result passes through the packet register and then the result
// register. in_stall rises only when both of those registers hold a packet and the output
// is stalled; otherwise a valid byte is accepted in every cycle. The user must write offsets
// through cfg_we/cfg_index/cfg_data only while idle; the block itself does not enforce this.
module encoder_packet_decoder import epd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [12:0]  cfg_data,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [7:0]   rx_byte,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [12:0]  angle_one,
  output logic [12:0]  angle_two,
  output logic [12:0]  angle_three,
  output logic         valid_one,
  output logic         valid_two,
  output logic         valid_three,
  output logic         checksum_ok
);

  angle_t     offset_one, offset_two, offset_three;
  pkt_t       pkt;
  logic [2:0] pos;
  logic       accept;
  logic       advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_one   <= '0;
      offset_two   <= '0;
      offset_three <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OFFSET_ONE:   offset_one   <= cfg_data;
        CFG_OFFSET_TWO:   offset_two   <= cfg_data;
        CFG_OFFSET_THREE: offset_three <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold the input only while a finished packet cannot move into the result register.
  assign in_stall = pkt.valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  epd_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .advance (advance),
    .pkt     (pkt),
    .pos     (pos)
  );

  epd_result u_result (
    .clk          (clk),
    .rst          (rst),
    .pkt          (pkt),
    .offset_one   (offset_one),
    .offset_two   (offset_two),
    .offset_three (offset_three),
    .out_stall    (out_stall),
    .advance      (advance),
    .out_valid    (out_valid),
    .angle_one    (angle_one),
    .angle_two    (angle_two),
    .angle_three  (angle_three),
    .valid_one    (valid_one),
    .valid_two    (valid_two),
    .valid_three  (valid_three),
    .checksum_ok  (checksum_ok)
  );

  a_check_makes_packet: assert property (@(posedge clk) disable iff (rst)
    accept && pos == POS_CHECK |=> pkt.valid)
    else $error("checksum byte did not produce a packet");

  a_packet_held: assert property (@(posedge clk) disable iff (rst)
    pkt.valid && !advance |=> pkt.valid)
    else $error("pending packet dropped while result register busy");

  a_hunt_drop: assert property (@(posedge clk) disable iff (rst)
    accept && pos == POS_HUNT && rx_byte != HDR_BYTE |=> pos == POS_HUNT)
    else $error("framer left hunt without a header");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !pkt.valid |-> !in_stall)
    else $error("input stalled with no pending packet");

endmodule
